[sv/sfr_pkg.sv]
// Shared constants, types and codes of the stream find-and-replace unit.
`default_nettype none

package sfr_pkg;

   localparam int BYTE_W              = 8;
   localparam int KEY_SLOTS           = 8;
   localparam int WORD_W              = BYTE_W * KEY_SLOTS;
   localparam int LEN_W               = 4;
   localparam int MAX_PATTERN_DEFAULT = 8;
   localparam int QUEUE_DEPTH         = 2;
   localparam int MAX_RESULTS         = 8;
   localparam int RES_CNT_W           = 4;
   localparam int CSR_INDEX_W         = 8;
   localparam int CSR_DATA_W          = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES          = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH         = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 8'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] key_bytes;
      logic [LEN_W-1:0]  key_length;
      logic [WORD_W-1:0] replacement_bytes;
      logic [LEN_W-1:0]  replacement_length;
   } cfg_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_REPL,
      ENG_FLUSH,
      ENG_FINISH
   } eng_state_type;

endpackage

`default_nettype wire

[sv/sfr_queue.sv]
// Small first-in first-out queue of register entries with full and empty flags.
`default_nettype none

module sfr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[sv/sfr_engine.sv]
// Back end: holds candidate bytes, matches them against the key and emits results.
`default_nettype none

module sfr_engine #(
   parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sfr_pkg::cfg_type      cfg,
   input  wire logic                  clear,
   input  wire sfr_pkg::req_item_type in_item,
   input  wire logic                  in_empty,
   output logic                       in_pop,
   output sfr_pkg::rsp_item_type      out_item,
   input  wire logic                  out_full,
   output logic                       out_push
);

   import sfr_pkg::*;

   localparam int LEN_LIMIT = (MAX_PATTERN < KEY_SLOTS) ? MAX_PATTERN : KEY_SLOTS;
   localparam int CNT_W     = $clog2(LEN_LIMIT + 1);
   localparam int IDX_W     = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;

   eng_state_type        state_ff, state_in;
   logic [BYTE_W-1:0]    win_ff [LEN_LIMIT];
   logic [BYTE_W-1:0]    win_in [LEN_LIMIT];
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RES_CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0]     r_ff, r_in;
   logic                 eot_ff, eot_in;
   rsp_item_type         pend_ff, pend_in;
   logic                 pend_v_ff, pend_v_in;

   logic [BYTE_W-1:0]    key_arr [LEN_LIMIT];
   logic [BYTE_W-1:0]    rep_arr [LEN_LIMIT];
   logic [CNT_W-1:0]     klen;
   logic [CNT_W-1:0]     rlen;
   logic [CNT_W-1:0]     cmp_len;
   logic                 match;
   logic                 emit;
   logic [BYTE_W-1:0]    emit_byte;
   logic                 room;
   logic                 stall;

   // Lengths outside the supported range are clamped; a zero key length acts as one.
   always_comb begin
      if (cfg.key_length == '0) begin
         klen = CNT_W'(1);
      end else if (cfg.key_length > LEN_W'(LEN_LIMIT)) begin
         klen = CNT_W'(LEN_LIMIT);
      end else begin
         klen = cfg.key_length[CNT_W-1:0];
      end
      if (cfg.replacement_length > LEN_W'(LEN_LIMIT)) begin
         rlen = CNT_W'(LEN_LIMIT);
      end else begin
         rlen = cfg.replacement_length[CNT_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < LEN_LIMIT; i++) begin
         key_arr[i] = cfg.key_bytes[BYTE_W*i +: BYTE_W];
         rep_arr[i] = cfg.replacement_bytes[BYTE_W*i +: BYTE_W];
      end
   end

   // The held bytes match when every compared position agrees with the key.
   always_comb begin
      cmp_len = (cnt_ff < klen) ? cnt_ff : klen;
      match   = 1'b1;
      for (int i = 0; i < LEN_LIMIT; i++) begin
         if ((CNT_W'(i) < cmp_len) && (win_ff[i] != key_arr[i])) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      win_in    = win_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      r_in      = r_ff;
      eot_in    = eot_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      in_pop    = 1'b0;
      out_push  = 1'b0;
      out_item  = pend_ff;
      emit      = 1'b0;
      emit_byte = win_ff[0];

      case (state_ff)
         ENG_IDLE: begin
            if (!in_empty) begin
               in_pop                     = 1'b1;
               win_in[cnt_ff[IDX_W-1:0]] = in_item.text_byte;
               cnt_in                     = cnt_ff + CNT_W'(1);
               n_in                       = '0;
               eot_in                     = in_item.end_of_text;
               state_in                   = ENG_SCAN;
            end
         end
         ENG_SCAN: begin
            if (cnt_ff == '0) begin
               state_in = ENG_FINISH;
            end else if (match) begin
               if (cnt_ff < klen) begin
                  state_in = eot_ff ? ENG_FLUSH : ENG_FINISH;
               end else if (rlen == '0) begin
                  // A full match always spans every held byte.
                  cnt_in = '0;
               end else begin
                  r_in     = '0;
                  state_in = ENG_REPL;
               end
            end else begin
               emit = 1'b1;
               for (int i = 0; i < LEN_LIMIT - 1; i++) begin
                  win_in[i] = win_ff[i + 1];
               end
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ENG_REPL: begin
            emit      = 1'b1;
            emit_byte = rep_arr[r_ff];
            if ((CNT_W'(r_ff) + CNT_W'(1)) == rlen) begin
               cnt_in   = '0;
               state_in = ENG_SCAN;
            end else begin
               r_in = r_ff + IDX_W'(1);
            end
         end
         ENG_FLUSH: begin
            emit = 1'b1;
            for (int i = 0; i < LEN_LIMIT - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ENG_FINISH;
            end
         end
         ENG_FINISH: begin
            if (pend_v_ff) begin
               out_item      = pend_ff;
               out_item.last = eot_ff;
               if (!out_full) begin
                  out_push  = 1'b1;
                  pend_v_in = 1'b0;
                  state_in  = ENG_IDLE;
               end
            end else if (eot_ff) begin
               out_item.out_byte = '0;
               out_item.has_byte = 1'b0;
               out_item.last     = 1'b1;
               if (!out_full) begin
                  out_push = 1'b1;
                  state_in = ENG_IDLE;
               end
            end else begin
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase

      // One result is kept back so the final one of a text can still be marked.
      room  = (n_ff < RES_CNT_W'(MAX_RESULTS));
      stall = emit && room && pend_v_ff && out_full;
      if (stall) begin
         state_in = state_ff;
         win_in   = win_ff;
         cnt_in   = cnt_ff;
         r_in     = r_ff;
      end else if (emit && room) begin
         if (pend_v_ff) begin
            out_push = 1'b1;
            out_item = pend_ff;
         end
         pend_in.out_byte = emit_byte;
         pend_in.has_byte = 1'b1;
         pend_in.last     = 1'b0;
         pend_v_in        = 1'b1;
         n_in             = n_ff + RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ENG_IDLE;
         cnt_ff    <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= clear ? '0 : cnt_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      n_ff    <= n_in;
      r_ff    <= r_in;
      eot_ff  <= eot_in;
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

[sv/stream_find_and_replace_unit.sv]
// Top level of the stream find-and-replace unit: registers, queues and match engine.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------------
//   req     | req_text_byte, req_end_of_text          | taken when push and not full
//   rsp     | rsp_out_byte, rsp_has_byte, rsp_last    | taken when pop and not empty
//   csr     | csr_index, csr_data                     | written when valid and ready
//
// An item is taken in the idle state, moves through scan, replace and flush as it releases bytes
// (bytes passed on after a mismatch, replacement bytes, bytes flushed at end of text) and ends in
// finish; the engine handles one released byte per cycle while the result queue has room.
// A two-entry queue on each side lets input and output stall independently of the engine.
// Reset is synchronous and empties both queues and the held window; csr_ready is always high.
// Writing the key or its length discards any held bytes.
`default_nettype none

module stream_find_and_replace_unit #(
   parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [sfr_pkg::BYTE_W-1:0]       req_text_byte,
   input  wire logic                             req_end_of_text,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic      [sfr_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                                  rsp_has_byte,
   output logic                                  rsp_last,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]   csr_data
);

   import sfr_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         key_write;
   logic         csr_write;
   req_item_type req_item;
   req_item_type eng_in_item;
   logic         eng_in_empty;
   logic         eng_in_pop;
   rsp_item_type eng_out_item;
   logic         eng_out_full;
   logic         eng_out_push;
   rsp_item_type rsp_item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in    = cfg_ff;
      key_write = 1'b0;
      if (csr_write) begin
         case (csr_index)
            CSR_KEY_BYTES: begin
               cfg_in.key_bytes = csr_data[WORD_W-1:0];
               key_write        = 1'b1;
            end
            CSR_KEY_LENGTH: begin
               cfg_in.key_length = csr_data[LEN_W-1:0];
               key_write         = 1'b1;
            end
            CSR_REPLACEMENT_BYTES: begin
               cfg_in.replacement_bytes = csr_data[WORD_W-1:0];
            end
            CSR_REPLACEMENT_LENGTH: begin
               cfg_in.replacement_length = csr_data[LEN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_bytes          <= '0;
         cfg_ff.key_length         <= LEN_W'(1);
         cfg_ff.replacement_bytes  <= '0;
         cfg_ff.replacement_length <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.text_byte   = req_text_byte;
   assign req_item.end_of_text = req_end_of_text;

   sfr_queue #(
      .WIDTH ($bits(req_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_req_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (req_item),
      .full    (req_full),
      .pop     (eng_in_pop),
      .rd_data (eng_in_item),
      .empty   (eng_in_empty)
   );

   sfr_engine #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .clear    (key_write),
      .in_item  (eng_in_item),
      .in_empty (eng_in_empty),
      .in_pop   (eng_in_pop),
      .out_item (eng_out_item),
      .out_full (eng_out_full),
      .out_push (eng_out_push)
   );

   sfr_queue #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (eng_out_push),
      .wr_data (eng_out_item),
      .full    (eng_out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_item),
      .empty   (rsp_empty)
   );

   assign rsp_out_byte = rsp_item.out_byte;
   assign rsp_has_byte = rsp_item.has_byte;
   assign rsp_last     = rsp_item.last;

endmodule

`default_nettype wire

[sv/sfr_checker.sv]
// Port-level checks of the stream find-and-replace unit, bound to its top level.
`default_nettype none

module sfr_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_full,
   input wire logic                             rsp_empty,
   input wire logic                             rsp_pop,
   input wire logic [sfr_pkg::BYTE_W-1:0]       rsp_out_byte,
   input wire logic                             rsp_has_byte,
   input wire logic                             rsp_last
);

   // Reset leaves no result waiting.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting right after reset");

   // Reset leaves room for input.
   assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full right after reset");

   // A waiting result that is not taken stays unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_has_byte) && $stable(rsp_last)))
      else $error("waiting result changed before it was taken");

   // An item without a byte is only ever the end marker of a text.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_has_byte) |-> (rsp_last && (rsp_out_byte == '0)))
      else $error("bare result is not a clean end marker");

endmodule

bind stream_find_and_replace_unit sfr_checker u_sfr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_out_byte (rsp_out_byte),
   .rsp_has_byte (rsp_has_byte),
   .rsp_last     (rsp_last)
);

`default_nettype wire

[verif/rewrite_checker.sv]
// Checker of the stream find-and-replace unit: predicts the rewritten text and compares results.
`timescale 1ns / 1ps

module rewrite_checker #(
   parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire logic                            req_full,
   input  wire logic [sfr_pkg::BYTE_W-1:0]      req_text_byte,
   input  wire logic                            req_end_of_text,
   input  wire logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   input  wire logic [sfr_pkg::BYTE_W-1:0]      rsp_out_byte,
   input  wire logic                            rsp_has_byte,
   input  wire logic                            rsp_last,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                   mismatch_count,
   output int                                   results_pending,
   output int                                   results_checked,
   output int                                   matches_replaced
);

   import sfr_pkg::*;

   localparam int LEN_CAP = (MAX_PATTERN < KEY_SLOTS) ? MAX_PATTERN : KEY_SLOTS;

   cfg_type           shadow_cfg;
   logic [BYTE_W-1:0] held_win [KEY_SLOTS];
   int                held_cnt;
   rsp_item_type      step_out [$];
   rsp_item_type      rewritten_q [$];
   int                n_mismatch = 0;
   int                n_checked = 0;
   int                n_replaced = 0;

   function automatic int eff_key_len();
      int k;
      k = int'(shadow_cfg.key_length);
      if (k == 0) k = 1;
      if (k > LEN_CAP) k = LEN_CAP;
      return k;
   endfunction

   function automatic int eff_rep_len();
      int r;
      r = int'(shadow_cfg.replacement_length);
      if (r > LEN_CAP) r = LEN_CAP;
      return r;
   endfunction

   // A single item never releases more than MAX_RESULTS bytes; extra ones are dropped.
   task automatic release_byte(input logic [BYTE_W-1:0] b);
      rsp_item_type r;
      if (step_out.size() < MAX_RESULTS) begin
         r.out_byte = b;
         r.has_byte = 1'b1;
         r.last     = 1'b0;
         step_out.push_back(r);
      end
   endtask

   task automatic drop_held(input int n);
      int i;
      if (n >= held_cnt) begin
         held_cnt = 0;
      end else begin
         for (i = 0; i < held_cnt - n; i++) held_win[i] = held_win[i + n];
         held_cnt -= n;
      end
   endtask

   task automatic apply_write(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_KEY_BYTES: begin
            shadow_cfg.key_bytes = data;
            held_cnt = 0;
         end
         CSR_KEY_LENGTH: begin
            shadow_cfg.key_length = data[LEN_W-1:0];
            held_cnt = 0;
         end
         CSR_REPLACEMENT_BYTES: shadow_cfg.replacement_bytes = data;
         CSR_REPLACEMENT_LENGTH: shadow_cfg.replacement_length = data[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic rewrite_step(input logic [BYTE_W-1:0] text_byte, input logic end_of_text);
      int           klen;
      int           rlen;
      int           span;
      int           i;
      logic         hit;
      rsp_item_type marker;
      klen = eff_key_len();
      rlen = eff_rep_len();
      step_out.delete();
      if (held_cnt > KEY_SLOTS - 1) held_cnt = 0;
      held_win[held_cnt] = text_byte;
      held_cnt++;
      // Release from the front until the held bytes are a proper prefix of the key.
      while (held_cnt > 0) begin
         span = (held_cnt < klen) ? held_cnt : klen;
         hit = 1'b1;
         for (i = 0; i < span; i++)
            if (held_win[i] != shadow_cfg.key_bytes[BYTE_W*i +: BYTE_W]) hit = 1'b0;
         if (hit && held_cnt < klen) break;
         if (hit) begin
            for (i = 0; i < rlen; i++)
               release_byte(shadow_cfg.replacement_bytes[BYTE_W*i +: BYTE_W]);
            drop_held(klen);
            n_replaced++;
         end else begin
            release_byte(held_win[0]);
            drop_held(1);
         end
      end
      if (end_of_text) begin
         for (i = 0; i < held_cnt; i++) release_byte(held_win[i]);
         held_cnt = 0;
         if (step_out.size() == 0) begin
            marker.out_byte = '0;
            marker.has_byte = 1'b0;
            marker.last     = 1'b1;
         end else begin
            marker = step_out.pop_back();
            marker.last = 1'b1;
         end
         step_out.push_back(marker);
      end
      foreach (step_out[j]) rewritten_q.push_back(step_out[j]);
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         shadow_cfg.key_bytes          = '0;
         shadow_cfg.key_length         = LEN_W'(1);
         shadow_cfg.replacement_bytes  = '0;
         shadow_cfg.replacement_length = '0;
         held_cnt = 0;
         rewritten_q.delete();
      end else begin
         if (csr_valid && csr_ready) apply_write(csr_index, csr_data);
         if (req_push && !req_full) rewrite_step(req_text_byte, req_end_of_text);
         if (rsp_pop && !rsp_empty) begin
            n_checked++;
            if (rewritten_q.size() == 0) begin
               $error("unexpected result: out_byte %02h has_byte %0b last %0b",
                      rsp_out_byte, rsp_has_byte, rsp_last);
               n_mismatch++;
            end else begin
               want = rewritten_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  n_mismatch++;
               end
               if (rsp_has_byte !== want.has_byte) begin
                  $error("has_byte: expected %0b, got %0b", want.has_byte, rsp_has_byte);
                  n_mismatch++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  n_mismatch++;
               end
            end
         end
      end
      mismatch_count   <= n_mismatch;
      results_pending  <= rewritten_q.size();
      results_checked  <= n_checked;
      matches_replaced <= n_replaced;
   end

endmodule

[verif/stream_find_and_replace_unit_tb.sv]
// Testbench top of the stream find-and-replace unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module stream_find_and_replace_unit_tb;
   import sfr_pkg::*;

   localparam int MAX_PATTERN   = MAX_PATTERN_DEFAULT;
   localparam int SETTLE_CYCLES = 60;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 360;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic [BYTE_W-1:0]      req_text_byte;
   logic                   req_end_of_text;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_has_byte;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int mismatch_count;
   int results_pending;
   int results_checked;
   int matches_replaced;

   bit                paced = 1'b1;  // low: both sides run without idle cycles
   logic [WORD_W-1:0] cur_key;
   int                cur_klen;
   logic [BYTE_W-1:0] text_q [$];
   int                items_sent = 0;
   int                texts_sent = 0;
   int                settings_used = 0;
   int                idle_cycles = 0;

   stream_find_and_replace_unit #(.MAX_PATTERN(MAX_PATTERN)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   rewrite_checker #(.MAX_PATTERN(MAX_PATTERN)) rewrite_check_u (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .results_pending  (results_pending),
      .results_checked  (results_checked),
      .matches_replaced (matches_replaced)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: any cycle with a handshake on some channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : result_drain
      int wait_cycles;
      rsp_pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         wait_cycles = paced ? $urandom_range(0, 3) : 0;
         if (wait_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic eot);
      int gap;
      gap = paced ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (eot) texts_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Lets every expected result come out and the engine finish items that release nothing.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_unit(input logic [WORD_W-1:0] key, input logic [LEN_W-1:0] klen,
                               input logic [WORD_W-1:0] rep, input logic [LEN_W-1:0] rlen,
                               input int stray_index);
      logic [CSR_DATA_W-1:0] len_word;
      settle();
      write_reg(CSR_KEY_BYTES, key);
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = klen;
      write_reg(CSR_KEY_LENGTH, len_word);
      write_reg(CSR_REPLACEMENT_BYTES, rep);
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = rlen;
      write_reg(CSR_REPLACEMENT_LENGTH, len_word);
      // Writes to unused indexes must leave the settings alone.
      if (stray_index >= 0) write_reg(CSR_INDEX_W'(stray_index), {$urandom, $urandom});
      csr_valid <= 1'b0;
      cur_key  = key;
      cur_klen = (klen == 0) ? 1 : ((klen > 8) ? 8 : int'(klen));
      settings_used++;
   endtask

   function automatic logic [WORD_W-1:0] two_symbol_key();
      logic [BYTE_W-1:0] sym_a;
      logic [BYTE_W-1:0] sym_b;
      logic [WORD_W-1:0] k;
      sym_a = 8'($urandom);
      sym_b = 8'($urandom);
      for (int i = 0; i < KEY_SLOTS; i++) begin
         k[BYTE_W*i +: BYTE_W] = $urandom_range(0, 1) ? sym_a : sym_b;
      end
      return k;
   endfunction

   // Mostly pieces of the key, whole or broken off, so that matches and mismatches are common.
   function automatic void build_text(input bit well_formed);
      int target;
      int cut;
      int pos;
      text_q.delete();
      target = $urandom_range(1, 12);
      while (text_q.size() < target) begin
         if (!well_formed) begin
            text_q.push_back(8'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  for (int i = 0; i < cur_klen; i++)
                     text_q.push_back(cur_key[BYTE_W*i +: BYTE_W]);
               end
               1: begin
                  cut = $urandom_range(1, cur_klen);
                  for (int i = 0; i < cut; i++) text_q.push_back(cur_key[BYTE_W*i +: BYTE_W]);
               end
               2: begin
                  pos = $urandom_range(0, cur_klen - 1);
                  text_q.push_back(cur_key[BYTE_W*pos +: BYTE_W]);
               end
               default: text_q.push_back(8'($urandom));
            endcase
         end
      end
   endfunction

   task automatic send_text(input bit cut);
      for (int i = 0; i < text_q.size(); i++)
         send_item(text_q[i], !cut && (i == text_q.size() - 1));
   endtask

   initial begin
      int               start_count;
      int               phase_start;
      int               phase_items;
      int               phase;
      bit               paused;
      bit               cut;
      logic [WORD_W-1:0] key;
      logic [LEN_W-1:0]  klen;
      logic [LEN_W-1:0]  rlen;

      reset           <= 1'b1;
      req_push        <= 1'b0;
      req_text_byte   <= '0;
      req_end_of_text <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= '0;
      csr_data        <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings delete every zero byte; a text of one deleted byte ends in a bare marker.
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'h00, 1'b1);

      // Full match, broken match and a flush of held bytes at end of text.
      program_unit({$urandom, 8'($urandom), 24'h636261}, 4'd3,
                   64'h5354_5556_5758_595A, 4'd8, 255);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(8'h63, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(8'h78, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b1);

      // Both lengths above the limit saturate to eight.
      program_unit('1, 4'hF, '0, 4'hF, 4);
      for (int i = 0; i < 8; i++) send_item(8'hFF, i == 7);

      // A key length of zero acts as one.
      program_unit({$urandom, 24'($urandom), 8'h5A}, 4'd0, 64'h3231, 4'd2, -1);
      send_item(8'h5A, 1'b0);
      send_item(8'h00, 1'b1);

      // Rewriting the key in the middle of a text throws the held bytes away.
      program_unit(64'h6261, 4'd2, {$urandom, $urandom}, 4'd1, -1);
      send_item(8'h61, 1'b0);
      settle();
      write_reg(CSR_KEY_BYTES, 64'h6162);
      csr_valid <= 1'b0;
      cur_key = 64'h6162;
      send_item(8'h62, 1'b1);

      start_count = items_sent;
      paused = 1'b0;
      for (phase = 0; items_sent - start_count < RANDOM_ITEMS; phase++) begin
         case (phase % 4)
            0: begin
               key  = two_symbol_key();
               klen = LEN_W'($urandom_range(1, 8));
               rlen = 4'd0;
            end
            1: begin
               key  = {$urandom, $urandom};
               klen = LEN_W'($urandom_range(0, 15));
               rlen = 4'd8;
            end
            2: begin
               key  = two_symbol_key();
               klen = 4'd8;
               rlen = LEN_W'($urandom_range(0, 15));
            end
            default: begin
               key  = {$urandom, $urandom};
               klen = 4'd1;
               rlen = LEN_W'($urandom_range(0, 15));
            end
         endcase
         program_unit(key, klen, {$urandom, $urandom}, rlen,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(4, 255) : -1);
         paced = (phase % 3 != 2);
         phase_items = $urandom_range(35, 50);
         phase_start = items_sent;
         while (items_sent - phase_start < phase_items) begin
            build_text($urandom_range(0, 3) != 0);
            // The last text of a phase is sometimes left open, so the next key write drops it.
            cut = (items_sent - phase_start + text_q.size() >= phase_items) &&
                  ($urandom_range(0, 1) == 1);
            send_text(cut);
            if (phase == 1 && !paused) begin
               req_push <= 1'b0;
               @(posedge clock);
               while (results_pending != 0) @(posedge clock);
               paused = 1'b1;
            end
         end
      end

      settle();
      $display("Run covered %0d text bytes in %0d finished texts under %0d register settings.",
               items_sent, texts_sent, settings_used);
      $display("%0d results checked, %0d key matches replaced, %0d mismatches.",
               results_checked, matches_replaced, mismatch_count);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
